/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed")

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed")

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* src/eeb_pkg.sv */
`default_nettype none

package eeb_pkg;

  // Operand and remainder widths
  localparam int OperandWidth = 32;
  localparam int RemWidth     = 31;
  localparam int ShiftWidth   = 5;

  typedef struct packed {
    logic signed [OperandWidth-1:0] value_a;
    logic signed [OperandWidth-1:0] value_b;
  } in_t;

  typedef struct packed {
    logic        [RemWidth-1:0]     divisor;
    logic signed [OperandWidth-1:0] coef_a;
    logic signed [OperandWidth-1:0] coef_b;
    logic                           bad_input;
  } out_t;

  // Control from the channel logic into the core
  typedef struct packed {
    logic start;
    logic take;
  } core_ctrl_t;

  // Status from the core back to the channel logic
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ALIGN = 5'b00010,
    ST_SUB   = 5'b00100,
    ST_SWAP  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

/* src/eeb_core.sv */
`default_nettype none

`include "assert_macros.svh"

module eeb_core (
  input  wire                   clk,
  input  wire                   rst,
  input  eeb_pkg::core_ctrl_t   ctrl,
  input  eeb_pkg::in_t          operands,
  output eeb_pkg::core_stat_t   stat,
  output eeb_pkg::out_t         result
);
  import eeb_pkg::*;

  state_t state;
  state_t state_next;

  // Remainder pair and coefficient pairs
  logic        [RemWidth-1:0]     r0;
  logic        [RemWidth-1:0]     r1;
  logic signed [OperandWidth-1:0] s0;
  logic signed [OperandWidth-1:0] s1;
  logic signed [OperandWidth-1:0] t0;
  logic signed [OperandWidth-1:0] t1;
  logic                           bad;

  // Shifted divisor and shifted coefficients of the current quotient step
  logic        [RemWidth-1:0]     d;
  logic signed [OperandWidth-1:0] ds;
  logic signed [OperandWidth-1:0] dt;
  logic        [ShiftWidth-1:0]   k;

  logic        [RemWidth:0]       d_dbl;
  logic                           align_go;
  logic                           sub_go;
  logic                           neg_in;

  // Compare logic: doubled divisor against remainder, divisor against remainder
  assign d_dbl    = {d, 1'b0};
  assign align_go = (d_dbl <= {1'b0, r0}) && !d[RemWidth-1];
  assign sub_go   = (d <= r0);
  assign neg_in   = operands.value_a[OperandWidth-1] | operands.value_b[OperandWidth-1];

  // Sequence the quotient steps
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctrl.start) begin
          if (neg_in || (operands.value_b == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (!align_go) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        if (k == '0) begin
          state_next = ST_SWAP;
        end
      end
      ST_SWAP: begin
        if (r0 == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_ALIGN;
        end
      end
      ST_DONE: begin
        if (ctrl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load, align, subtract, swap
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (ctrl.start) begin
          bad <= neg_in;
          if (neg_in) begin
            r0 <= '0;
            s0 <= '0;
            t0 <= '0;
          end else begin
            r0 <= operands.value_a[RemWidth-1:0];
            s0 <= OperandWidth'(1);
            t0 <= '0;
          end
          r1 <= operands.value_b[RemWidth-1:0];
          s1 <= '0;
          t1 <= OperandWidth'(1);
          d  <= operands.value_b[RemWidth-1:0];
          ds <= '0;
          dt <= OperandWidth'(1);
          k  <= '0;
        end
      end
      ST_ALIGN: begin
        if (align_go) begin
          d  <= d_dbl[RemWidth-1:0];
          ds <= ds <<< 1;
          dt <= dt <<< 1;
          k  <= k + ShiftWidth'(1);
        end
      end
      ST_SUB: begin
        if (sub_go) begin
          r0 <= r0 - d;
          s0 <= s0 - ds;
          t0 <= t0 - dt;
        end
        d  <= d >> 1;
        ds <= ds >>> 1;
        dt <= dt >>> 1;
        if (k != '0) begin
          k <= k - ShiftWidth'(1);
        end
      end
      ST_SWAP: begin
        // r0 now holds the remainder; it becomes the next divisor
        r0 <= r1;
        r1 <= r0;
        s0 <= s1;
        s1 <= s0;
        t0 <= t1;
        t1 <= t0;
        d  <= r0;
        ds <= s0;
        dt <= t0;
        k  <= '0;
      end
      default: begin
      end
    endcase
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_DONE) && ctrl.take;

  assign result.divisor   = r0;
  assign result.coef_a    = s0;
  assign result.coef_b    = t0;
  assign result.bad_input = bad;

  // The core only starts from idle
  `ASSERT_CLK(a_start_idle, ctrl.start |-> (state == ST_IDLE));
  // Alignment never pushes the divisor past the remainder
  `ASSERT_CLK(a_align_bound, ((state == ST_ALIGN) && (k != '0)) |-> (d <= r0));
  // A quotient step always divides by a nonzero value
  `ASSERT_CLK(a_div_nonzero, ((state == ST_ALIGN) || (state == ST_SUB)) |-> (d != '0));
  // After the subtract phase the remainder is below the divisor
  `ASSERT_CLK(a_rem_below, (state == ST_SWAP) |-> (r0 < r1));
  // Rejected operands give zero results
  `ASSERT_CLK(a_bad_zero,
    ((state == ST_DONE) && bad) |-> ((r0 == '0) && (s0 == '0) && (t0 == '0)));

endmodule

`default_nettype wire

/* src/extended_euclid_bezout.sv */
`default_nettype none

// Channel  Handshake          Payload
// in       in_valid/in_stall  in_data  (value_a, value_b)
// out      out_valid/out_stall out_data (divisor, coef_a, coef_b, bad_input)
//
// One transaction at a time; in_stall stays high until the result is loaded.
// Each quotient step aligns the divisor in ALIGN, subtracts bit by bit in SUB, then swaps
// the pairs in SWAP, using the shift/compare/subtract datapath.
// A negative operand or a zero value_b goes from idle straight to done.
// rst is synchronous and clears the sequencer and the output valid.
// The result register lets a new transaction start while out_stall holds one.
module extended_euclid_bezout (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_stall,
  input  eeb_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output eeb_pkg::out_t  out_data
);
  import eeb_pkg::*;

  core_ctrl_t ctrl;
  core_stat_t stat;
  out_t       result;

  assign in_stall   = stat.busy;
  assign ctrl.start = in_valid && !stat.busy;
  assign ctrl.take  = !out_valid || !out_stall;

  eeb_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .operands (in_data),
    .stat     (stat),
    .result   (result)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_extended_euclid_bezout.sv */
`timescale 1ns / 100ps

module tb_extended_euclid_bezout;
  import eeb_pkg::*;

  localparam int RandomPairs = 1430;
  localparam int IdleLimit   = 5000;
  localparam int SettleLen   = 200;

  typedef struct {
    in_t pair;
    bit  drain_first;
  } pending_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pending_pair_t operand_q[$];
  pending_pair_t next_pair;
  out_t          bezout_q[$];
  int            pairs_total;
  int            pairs_taken = 0;
  int            mismatches = 0;
  int            gap_left = 0;
  int            quiet_pairs = 0;
  int            stall_left = 0;
  int            calm_left = 0;
  int            idle_cycles = 0;
  logic [31:0]   fib[0:46];

  extended_euclid_bezout u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Compute gcd and Bezout coefficients by the remainder sequence
  function automatic out_t bezout_of(in_t op);
    logic [31:0] r0, r1, r2, quo;
    longint      s0, s1, s2, t0, t1, t2;
    out_t        res;
    res = '0;
    if (op.value_a[31] || op.value_b[31]) begin
      res.bad_input = 1'b1;
      return res;
    end
    r0 = op.value_a;
    r1 = op.value_b;
    s0 = 1;
    s1 = 0;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      quo = r0 / r1;
      r2  = r0 % r1;
      s2  = s0 - longint'({32'd0, quo}) * s1;
      t2  = t0 - longint'({32'd0, quo}) * t1;
      r0 = r1;
      r1 = r2;
      s0 = s1;
      s1 = s2;
      t0 = t1;
      t1 = t2;
    end
    res.divisor = r0[30:0];
    res.coef_a  = s0[31:0];
    res.coef_b  = t0[31:0];
    return res;
  endfunction

  task automatic add_pair(logic [31:0] a, logic [31:0] b, bit drain);
    pending_pair_t p;
    p.pair.value_a = a;
    p.pair.value_b = b;
    p.drain_first  = drain;
    operand_q.push_back(p);
  endtask

  // Short gaps mostly, often none, and an occasional long one
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_random_pair(bit drain);
    int          k, n;
    logic [31:0] a, b, g;
    k = $urandom_range(0, 99);
    if (k < 6) begin
      a = $urandom | 32'h8000_0000;
      b = $urandom;
    end else if (k < 14) begin
      a = $urandom;
      b = $urandom;
    end else if (k < 50) begin
      a = $urandom & 32'h7fff_ffff;
      b = $urandom & 32'h7fff_ffff;
    end else if (k < 68) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else if (k < 84) begin
      g = $urandom_range(1, 65535);
      a = g * $urandom_range(0, 32767);
      b = g * $urandom_range(0, 32767);
    end else if (k < 94) begin
      n = $urandom_range(1, 45);
      a = fib[n + 1];
      b = fib[n];
      if ($urandom_range(0, 1)) begin
        g = a;
        a = b;
        b = g;
      end
    end else begin
      a = $urandom & 32'h7fff_ffff;
      b = 32'd0;
      if ($urandom_range(0, 1)) begin
        b = a;
        a = 32'd0;
      end
    end
    add_pair(a, b, drain);
  endtask

  task automatic report_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: present pending pairs, with random idle gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bezout_q.push_back(bezout_of(in_data));
        pairs_taken <= pairs_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (operand_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (operand_q[0].drain_first && bezout_q.size() != 0) begin
          // hold off until every pending result has come back
          in_valid <= 1'b0;
        end else begin
          next_pair = operand_q.pop_front();
          in_data  <= next_pair.pair;
          in_valid <= 1'b1;
          if (quiet_pairs > 0) begin
            quiet_pairs <= quiet_pairs - 1;
            gap_left    <= 0;
          end else begin
            if ($urandom_range(0, 99) < 4) quiet_pairs <= $urandom_range(20, 60);
            gap_left <= pick_gap();
          end
        end
      end
    end
  end

  // Monitor: check results in order and drive random stall runs
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (bezout_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, actual divisor %0d coef_a %0d coef_b %0d bad %0b",
                   $time, out_data.divisor, out_data.coef_a, out_data.coef_b,
                   out_data.bad_input);
        end else begin
          out_t want;
          want = bezout_q.pop_front();
          report_field("divisor", longint'(want.divisor), longint'(out_data.divisor));
          report_field("coef_a", longint'(want.coef_a), longint'(out_data.coef_a));
          report_field("coef_b", longint'(want.coef_b), longint'(out_data.coef_b));
          report_field("bad_input", longint'(want.bad_input),
                       longint'(out_data.bad_input));
        end
      end
      if (calm_left > 0) begin
        calm_left <= calm_left - 1;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        calm_left <= $urandom_range(50, 300);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left <= pick_gap();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of test
  initial begin
    fib[0] = 32'd0;
    fib[1] = 32'd1;
    for (int i = 2; i <= 46; i++) fib[i] = fib[i - 1] + fib[i - 2];

    // directed: zero operands, extremes, negatives, worst-case step count
    add_pair(32'd0, 32'd0, 1'b0);
    add_pair(32'd123456, 32'd0, 1'b0);
    add_pair(32'd0, 32'd98765, 1'b0);
    add_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_pair(32'h7fff_ffff, 32'd1, 1'b0);
    add_pair(32'd1, 32'h7fff_ffff, 1'b0);
    add_pair(32'h7fff_ffff, 32'h7fff_fffe, 1'b0);
    add_pair(32'h8000_0000, 32'd5, 1'b0);
    add_pair(32'd5, 32'h8000_0000, 1'b0);
    add_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_pair(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_pair(32'hffff_ffff, 32'd0, 1'b0);
    add_pair(32'd0, 32'hffff_ffff, 1'b0);
    add_pair(fib[46], fib[45], 1'b0);
    add_pair(fib[45], fib[46], 1'b0);
    add_pair(32'd12, 32'd18, 1'b0);
    add_pair(32'd240, 32'd46, 1'b0);
    add_pair(32'd17, 32'd5, 1'b0);
    add_pair(32'd1, 32'd1, 1'b0);
    add_pair(32'h4000_0000, 32'd2, 1'b0);
    add_pair(32'd2, 32'h4000_0000, 1'b0);
    add_pair(32'h5555_5555, 32'h2aaa_aaaa, 1'b0);
    add_pair(32'd1000000007, 32'd998244353, 1'b0);

    // random part, draining the pipe now and then
    for (int i = 0; i < RandomPairs; i++) begin
      add_random_pair(i == 0 || $urandom_range(0, 299) == 0);
    end
    pairs_total = operand_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pairs_taken < pairs_total) @(posedge clk);
    while (bezout_q.size() != 0) @(posedge clk);
    repeat (SettleLen) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/eeb_pkg.sv
src/eeb_core.sv
src/extended_euclid_bezout.sv
verif/tb_extended_euclid_bezout.sv
